/* sv/cbi_pkg.sv */
// ----------------------------------------------------------------------------
// cbi_pkg
// Shared types, constants and helpers for the CSS brace indenter.
// ----------------------------------------------------------------------------
package cbi_pkg;

    // widths
    localparam int DEPTH_W = 6;
    localparam int TAB_W   = 6;
    localparam int BASE_W  = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // nesting limit and indent cap
    localparam logic [DEPTH_W-1:0] MAX_DEPTH = 6'd32;
    localparam logic [TAB_W-1:0]   TAB_CAP   = 6'd47;

    // register map: bit 2 of the byte address selects the register slot
    localparam logic REG_BASE_INDENT = 1'b0;

    // character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_OPEN  = 8'h7B;
    localparam logic [7:0] CHR_CLOSE = 8'h7D;

    // input kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       balanced;
        logic       last_of_run;
    } res_t;

    // character class of an input beat
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_SEMI,
        CLS_OTHER,
        CLS_END
    } cls_t;

    // output character source
    typedef enum logic [2:0] {
        SEL_TAB,
        SEL_CR,
        SEL_LF,
        SEL_SPACE,
        SEL_CHAR
    } out_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     emit;
        out_sel_t sel;
        logic     last;
        logic     tab_step;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cls_t cls;
        logic at_line_start;
        logic prev_was_space;
        logic indent_zero;
        logic tab_last;
        logic out_free;
    } dp_status_t;

    // classify one input beat
    function automatic cls_t classify(input item_t it);
        cls_t c;
        if (it.kind == KIND_END)
            c = CLS_END;
        else if (it.data_byte inside {CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF})
            c = CLS_SPACE;
        else if (it.data_byte == CHR_OPEN)
            c = CLS_OPEN;
        else if (it.data_byte == CHR_CLOSE)
            c = CLS_CLOSE;
        else if (it.data_byte == CHR_SEMI)
            c = CLS_SEMI;
        else
            c = CLS_OTHER;
        return c;
    endfunction

endpackage

/* sv/css_brace_indenter_unit.sv */
// ----------------------------------------------------------------------------
// css_brace_indenter_unit
// Reformats a CSS byte stream with line breaks and tab indentation and
// reports brace balance on an end-of-buffer beat.
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+-----------------------------
//   item     | item_valid, item_ready, item     | one CSS byte or end marker
//   res      | res_valid, res_ready, res        | one output char or status
//   config   | psel penable pwrite paddr pwdata | base_indent at address 0
//            | prdata pready                    |
//
// An item is taken only while the sequencer is idle, then each of its output
// beats passes through the output register; indent runs emit one tab per
// cycle from a down counter while res is not stalled.
// A whitespace byte that follows whitespace is taken with no beat.
// Reset restores line start, zero depth and base_indent 0.
// A stall on res holds the sequencer in its current phase.
// ----------------------------------------------------------------------------
module css_brace_indenter_unit
    import cbi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ctl_cmd_t          cmd;
    dp_status_t        st;
    logic              cfg_we;
    logic [BASE_W-1:0] base_indent;

    // register port decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BASE_INDENT);
    assign prdata = (paddr[2] == REG_BASE_INDENT)
                  ? {{(DATA_W - BASE_W){1'b0}}, base_indent} : '0;

    cbi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    cbi_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[BASE_W-1:0]),
        .base_indent (base_indent),
        .cmd         (cmd),
        .st          (st),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

/* sv/cbi_ctrl.sv */
// ----------------------------------------------------------------------------
// cbi_ctrl
// Sequencer that walks one item through its output phases: leading line
// break or separating space, indent tabs, the character itself and the
// trailing line break.
// ----------------------------------------------------------------------------
module cbi_ctrl
    import cbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t st,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_CR,
        ST_PRE_LF,
        ST_PRE_SP,
        ST_INDENT,
        ST_CHAR,
        ST_EOL_CR,
        ST_EOL_LF
    } state_t;

    state_t state_reg, state_next;
    logic   want_indent_reg, want_indent_next;
    logic   want_eol_reg, want_eol_next;
    logic   do_indent;

    assign item_ready = (state_reg == ST_IDLE);

    // command decode
    always_comb
    begin
        cmd.accept   = item_ready && item_valid;
        cmd.emit     = (state_reg != ST_IDLE) && st.out_free;
        cmd.last     = ((state_reg == ST_CHAR) && !want_eol_reg) || (state_reg == ST_EOL_LF);
        cmd.tab_step = (state_reg == ST_INDENT) && st.out_free;
        case (state_reg)
            ST_PRE_CR, ST_EOL_CR: cmd.sel = SEL_CR;
            ST_PRE_LF, ST_EOL_LF: cmd.sel = SEL_LF;
            ST_PRE_SP:            cmd.sel = SEL_SPACE;
            ST_INDENT:            cmd.sel = SEL_TAB;
            default:              cmd.sel = SEL_CHAR;
        endcase
    end

    // phase sequencing
    always_comb
    begin
        state_next       = state_reg;
        want_indent_next = want_indent_reg;
        want_eol_next    = want_eol_reg;
        do_indent        = st.at_line_start && !st.indent_zero;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    want_indent_next = 1'b0;
                    want_eol_next    = 1'b0;
                    case (st.cls)
                        CLS_END:
                            state_next = ST_CHAR;
                        CLS_SPACE:
                            state_next = st.prev_was_space ? ST_IDLE : ST_CHAR;
                        CLS_OPEN:
                        begin
                            want_eol_next = 1'b1;
                            // a run of text before the brace ends in one space
                            if (!st.prev_was_space)
                                state_next = ST_PRE_SP;
                            else
                                state_next = do_indent ? ST_INDENT : ST_CHAR;
                        end
                        CLS_CLOSE:
                        begin
                            want_eol_next    = 1'b1;
                            want_indent_next = !st.indent_zero;
                            if (!st.at_line_start)
                                state_next = ST_PRE_CR;
                            else
                                state_next = st.indent_zero ? ST_CHAR : ST_INDENT;
                        end
                        CLS_SEMI:
                        begin
                            want_eol_next = 1'b1;
                            state_next    = do_indent ? ST_INDENT : ST_CHAR;
                        end
                        default:
                            state_next = do_indent ? ST_INDENT : ST_CHAR;
                    endcase
                end
            end
            ST_PRE_CR:
                if (st.out_free)
                    state_next = ST_PRE_LF;
            ST_PRE_LF:
                if (st.out_free)
                    state_next = want_indent_reg ? ST_INDENT : ST_CHAR;
            ST_PRE_SP:
                if (st.out_free)
                    state_next = ST_CHAR;
            ST_INDENT:
                if (st.out_free && st.tab_last)
                    state_next = ST_CHAR;
            ST_CHAR:
                if (st.out_free)
                    state_next = want_eol_reg ? ST_EOL_CR : ST_IDLE;
            ST_EOL_CR:
                if (st.out_free)
                    state_next = ST_EOL_LF;
            ST_EOL_LF:
                if (st.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state and plan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            want_indent_reg <= 1'b0;
            want_eol_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            want_indent_reg <= want_indent_next;
            want_eol_reg    <= want_eol_next;
        end
    end

endmodule

/* sv/cbi_datapath.sv */
// ----------------------------------------------------------------------------
// cbi_datapath
// Formatter state, indent counter, item latch and the output register.
// ----------------------------------------------------------------------------
module cbi_datapath
    import cbi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata,
    output logic [BASE_W-1:0] base_indent,
    input  ctl_cmd_t          cmd,
    output dp_status_t        st,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    logic               at_line_start_reg, at_line_start_next;
    logic               prev_was_space_reg, prev_was_space_next;
    logic [DEPTH_W-1:0] nest_depth_reg, nest_depth_next;
    logic               depth_fault_reg, depth_fault_next;
    logic [BASE_W-1:0]  base_indent_reg;
    logic [TAB_W-1:0]   tab_cnt_reg, tab_cnt_next;
    logic [7:0]         char_reg, char_next;
    logic               status_reg, status_next;
    logic               balanced_reg, balanced_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    cls_t               cls;
    logic [DEPTH_W-1:0] depth_used;
    logic [TAB_W:0]     indent_sum;
    logic [TAB_W-1:0]   indent_cnt;

    assign cls         = classify(item);
    assign base_indent = base_indent_reg;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    // indent count for the incoming item; a close indents at its new depth
    always_comb
    begin
        if ((cls == CLS_CLOSE) && (nest_depth_reg != '0))
            depth_used = nest_depth_reg - DEPTH_W'(1);
        else
            depth_used = nest_depth_reg;
        indent_sum = {{(TAB_W + 1 - BASE_W){1'b0}}, base_indent_reg}
                   + {{(TAB_W + 1 - DEPTH_W){1'b0}}, depth_used};
        indent_cnt = (indent_sum > {1'b0, TAB_CAP}) ? TAB_CAP : indent_sum[TAB_W-1:0];
    end

    // status to controller
    always_comb
    begin
        st.cls            = cls;
        st.at_line_start  = at_line_start_reg;
        st.prev_was_space = prev_was_space_reg;
        st.indent_zero    = (indent_cnt == '0);
        st.tab_last       = (tab_cnt_reg == TAB_W'(1));
        st.out_free       = !res_valid_reg || res_ready;
    end

    // formatter state and item latch
    always_comb
    begin
        at_line_start_next  = at_line_start_reg;
        prev_was_space_next = prev_was_space_reg;
        nest_depth_next     = nest_depth_reg;
        depth_fault_next    = depth_fault_reg;
        char_next           = char_reg;
        status_next         = status_reg;
        balanced_next       = balanced_reg;
        tab_cnt_next        = tab_cnt_reg;
        if (cmd.tab_step)
            tab_cnt_next = tab_cnt_reg - TAB_W'(1);
        if (cmd.accept)
        begin
            tab_cnt_next  = indent_cnt;
            char_next     = item.data_byte;
            status_next   = 1'b0;
            balanced_next = 1'b0;
            case (cls)
                CLS_END:
                begin
                    char_next           = CHR_NUL;
                    status_next         = 1'b1;
                    balanced_next       = (nest_depth_reg == '0) && !depth_fault_reg;
                    at_line_start_next  = 1'b1;
                    prev_was_space_next = 1'b1;
                    nest_depth_next     = '0;
                    depth_fault_next    = 1'b0;
                end
                CLS_SPACE:
                begin
                    char_next           = CHR_SPACE;
                    prev_was_space_next = 1'b1;
                end
                CLS_OPEN:
                begin
                    at_line_start_next  = 1'b1;
                    prev_was_space_next = 1'b1;
                    if (nest_depth_reg >= MAX_DEPTH)
                    begin
                        nest_depth_next  = MAX_DEPTH;
                        depth_fault_next = 1'b1;
                    end
                    else
                        nest_depth_next = nest_depth_reg + DEPTH_W'(1);
                end
                CLS_CLOSE:
                begin
                    at_line_start_next  = 1'b1;
                    prev_was_space_next = 1'b1;
                    if (nest_depth_reg == '0)
                        depth_fault_next = 1'b1;
                    else
                        nest_depth_next = nest_depth_reg - DEPTH_W'(1);
                end
                CLS_SEMI:
                begin
                    at_line_start_next  = 1'b1;
                    prev_was_space_next = 1'b1;
                end
                default:
                begin
                    at_line_start_next  = 1'b0;
                    prev_was_space_next = 1'b0;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (cmd.emit)
        begin
            res_valid_next       = 1'b1;
            res_next.is_status   = 1'b0;
            res_next.balanced    = 1'b0;
            res_next.last_of_run = cmd.last;
            case (cmd.sel)
                SEL_TAB:   res_next.out_byte = CHR_TAB;
                SEL_CR:    res_next.out_byte = CHR_CR;
                SEL_LF:    res_next.out_byte = CHR_LF;
                SEL_SPACE: res_next.out_byte = CHR_SPACE;
                default:
                begin
                    res_next.out_byte  = char_reg;
                    res_next.is_status = status_reg;
                    res_next.balanced  = balanced_reg;
                end
            endcase
        end
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg  <= 1'b1;
            prev_was_space_reg <= 1'b1;
            nest_depth_reg     <= '0;
            depth_fault_reg    <= 1'b0;
            base_indent_reg    <= '0;
            tab_cnt_reg        <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            at_line_start_reg  <= at_line_start_next;
            prev_was_space_reg <= prev_was_space_next;
            nest_depth_reg     <= nest_depth_next;
            depth_fault_reg    <= depth_fault_next;
            tab_cnt_reg        <= tab_cnt_next;
            res_valid_reg      <= res_valid_next;
            if (cfg_we)
                base_indent_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        status_reg   <= status_next;
        balanced_reg <= balanced_next;
        res_reg      <= res_next;
    end

endmodule

/* sv/cbi_checker.sv */
// ----------------------------------------------------------------------------
// cbi_checker
// Port-level checks for the CSS brace indenter, bound to the top level.
// ----------------------------------------------------------------------------
module cbi_checker
    import cbi_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  item_valid,
    input logic  item_ready,
    input item_t item,
    input logic  res_valid,
    input logic  res_ready,
    input res_t  res
);

    // a stalled output beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("output beat changed while stalled");

    // a status beat ends its run and carries no character
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_status |-> res.last_of_run && (res.out_byte == CHR_NUL))
        else $error("malformed status beat");

    // balance is reported only on status beats
    a_balanced_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_status |-> !res.balanced)
        else $error("balanced set on a character beat");

    // a carriage return is always followed by a line feed of the same run
    a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_status && (res.out_byte == CHR_CR) |-> !res.last_of_run)
        else $error("run ends on a carriage return");

    // an end marker always produces a beat, so input must pause
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.kind == KIND_END) |=> !item_ready)
        else $error("end marker taken without a status beat");

endmodule

bind css_brace_indenter_unit cbi_checker u_cbi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CSS brace indenter. A directed table covers
// reset state, field extremes, every character class and the brace faults,
// then random style sheets, noise and deep nesting run under several
// base_indent settings with random stalls on both beat channels. Every
// output beat is checked against a typed table row or an in-bench formatter.
// ----------------------------------------------------------------------------
module testbench
    import cbi_pkg::*;
();

    localparam int TABLE_ROWS     = 22;
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [ADDR_W-1:0] BASE_ADDR = {REG_BASE_INDENT, 2'b00};

    localparam logic [BASE_W-1:0] PHASE_BASE [PHASES] =
        '{4'd15, 4'd0, 4'd0, 4'd5, 4'd15, 4'd0};

    localparam res_t NO_BEAT    = '0;
    localparam res_t STATUS_OK  =
        '{out_byte: CHR_NUL, is_status: 1'b1, balanced: 1'b1, last_of_run: 1'b1};
    localparam res_t STATUS_BAD =
        '{out_byte: CHR_NUL, is_status: 1'b1, balanced: 1'b0, last_of_run: 1'b1};

    // one row of the directed script
    typedef struct packed {
        item_t      beat;
        logic       from_model;
        logic [1:0] n_typed;
        res_t [0:2] typed;
    } step_row_t;

    function automatic res_t text_beat(input logic [7:0] c, input logic last);
        res_t r;
        r = '{out_byte: c, is_status: 1'b0, balanced: 1'b0, last_of_run: last};
        return r;
    endfunction

    function automatic step_row_t model_row(input logic k, input logic [7:0] b);
        step_row_t row;
        row = '0;
        row.beat = '{kind: k, data_byte: b};
        row.from_model = 1'b1;
        return row;
    endfunction

    function automatic step_row_t fixed_row(input logic k, input logic [7:0] b,
            input int n, input res_t r0, input res_t r1, input res_t r2);
        step_row_t row;
        row.beat = '{kind: k, data_byte: b};
        row.from_model = 1'b0;
        row.n_typed = 2'(n);
        row.typed = {r0, r1, r2};
        return row;
    endfunction

    // directed script, base_indent at its reset value
    step_row_t script [TABLE_ROWS] = '{
        fixed_row(KIND_END, CHR_NUL, 1, STATUS_OK, NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, "a", 1, text_beat("a", 1'b1), NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, CHR_SPACE, 1, text_beat(CHR_SPACE, 1'b1), NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, CHR_TAB, 0, NO_BEAT, NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, CHR_CR, 0, NO_BEAT, NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, CHR_LF, 0, NO_BEAT, NO_BEAT, NO_BEAT),
        fixed_row(KIND_BYTE, "b", 1, text_beat("b", 1'b1), NO_BEAT, NO_BEAT),
        model_row(KIND_BYTE, CHR_OPEN),
        model_row(KIND_BYTE, 8'hFF),
        fixed_row(KIND_BYTE, CHR_SEMI, 3, text_beat(CHR_SEMI, 1'b0),
                  text_beat(CHR_CR, 1'b0), text_beat(CHR_LF, 1'b1)),
        model_row(KIND_BYTE, 8'h00),
        model_row(KIND_BYTE, CHR_CLOSE),
        // close with nothing open: fault, depth stays at zero
        fixed_row(KIND_BYTE, CHR_CLOSE, 3, text_beat(CHR_CLOSE, 1'b0),
                  text_beat(CHR_CR, 1'b0), text_beat(CHR_LF, 1'b1)),
        fixed_row(KIND_END, 8'hFF, 1, STATUS_BAD, NO_BEAT, NO_BEAT),
        model_row(KIND_BYTE, CHR_SEMI),
        model_row(KIND_BYTE, CHR_OPEN),
        model_row(KIND_BYTE, CHR_OPEN),
        model_row(KIND_BYTE, "x"),
        // still two levels open
        fixed_row(KIND_END, CHR_NUL, 1, STATUS_BAD, NO_BEAT, NO_BEAT),
        model_row(KIND_BYTE, 8'h7F),
        model_row(KIND_BYTE, 8'h80),
        fixed_row(KIND_END, CHR_NUL, 1, STATUS_OK, NO_BEAT, NO_BEAT)
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    item_t             item       = '0;
    logic              res_valid;
    logic              res_ready  = 1'b0;
    res_t              res;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    css_brace_indenter_unit dut (.*);

    always #2 clk = ~clk;

    // formatter state, mirrors the block
    logic               line_start  = 1'b1;
    logic               after_space = 1'b1;
    logic [DEPTH_W-1:0] depth       = '0;
    logic               fault       = 1'b0;
    logic [BASE_W-1:0]  base_tabs   = '0;

    res_t beat_run [$];
    res_t pending_beats [$];
    res_t want_beat;
    int   items_sent   = 0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    bit   src_idle     = 1'b1;
    bit   sink_idle    = 1'b1;
    bit   hold_long    = 1'b0;

    function automatic void add_char(input logic [7:0] c);
        beat_run.push_back(text_beat(c, 1'b0));
    endfunction

    function automatic void add_eol();
        add_char(CHR_CR);
        add_char(CHR_LF);
    endfunction

    function automatic void add_indent();
        int tabs;
        tabs = int'(base_tabs) + int'(depth);
        if (tabs > int'(TAB_CAP))
            tabs = int'(TAB_CAP);
        for (int i = 0; i < tabs; i++)
            add_char(CHR_TAB);
    endfunction

    // works out the beats one input causes and advances the formatter state
    function automatic void format_beat(input item_t it);
        beat_run.delete();
        if (it.kind == KIND_END)
        begin
            beat_run.push_back('{out_byte: CHR_NUL, is_status: 1'b1,
                                 balanced: (depth == '0) && !fault, last_of_run: 1'b1});
            line_start  = 1'b1;
            after_space = 1'b1;
            depth       = '0;
            fault       = 1'b0;
        end
        else
        begin
            case (it.data_byte)
                CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF:
                begin
                    if (!after_space)
                        add_char(CHR_SPACE);
                    after_space = 1'b1;
                end
                CHR_OPEN:
                begin
                    if (!after_space)
                        add_char(CHR_SPACE);
                    else if (line_start)
                        add_indent();
                    add_char(CHR_OPEN);
                    add_eol();
                    // saturate at the nesting limit
                    if (depth >= MAX_DEPTH)
                    begin
                        depth = MAX_DEPTH;
                        fault = 1'b1;
                    end
                    else
                        depth = depth + 1'b1;
                    line_start  = 1'b1;
                    after_space = 1'b1;
                end
                CHR_CLOSE:
                begin
                    if (!line_start)
                        add_eol();
                    if (depth == '0)
                        fault = 1'b1;
                    else
                        depth = depth - 1'b1;
                    add_indent();
                    add_char(CHR_CLOSE);
                    add_eol();
                    line_start  = 1'b1;
                    after_space = 1'b1;
                end
                CHR_SEMI:
                begin
                    if (line_start)
                        add_indent();
                    add_char(CHR_SEMI);
                    add_eol();
                    line_start  = 1'b1;
                    after_space = 1'b1;
                end
                default:
                begin
                    if (line_start)
                    begin
                        line_start = 1'b0;
                        add_indent();
                    end
                    add_char(it.data_byte);
                    after_space = 1'b0;
                end
            endcase
            if (beat_run.size() != 0)
                beat_run[beat_run.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic void queue_run();
        foreach (beat_run[i])
            pending_beats.push_back(beat_run[i]);
    endfunction

    // offer one input beat, wait for the handshake, then predict
    task automatic send_beat(input item_t it);
        int gap;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        format_beat(it);
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_beat('{kind: KIND_BYTE, data_byte: c});
        queue_run();
    endtask

    task automatic send_end();
        send_beat('{kind: KIND_END, data_byte: 8'($urandom_range(0, 255))});
        queue_run();
    endtask

    // wait until every expected beat is out and the block has gone quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write base_indent, then read it back
    task automatic write_base(input logic [BASE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        base_tabs = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== DATA_W'(value))
        begin
            $display("%0t: base_indent readback mismatch, expected %0h, got %0h",
                     $time, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic bit is_special(input logic [7:0] c);
        bit s;
        case (c)
            CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF, CHR_OPEN, CHR_CLOSE, CHR_SEMI: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CHR_SPACE;
            1: c = CHR_TAB;
            2: c = CHR_CR;
            default: c = CHR_LF;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_special();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = pick_space();
            1: c = CHR_OPEN;
            2: c = CHR_CLOSE;
            default: c = CHR_SEMI;
        endcase
        return c;
    endfunction

    // mostly printable text, now and then any byte that is not special
    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 5) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(33, 126));
        end
        while (is_special(c));
        return c;
    endfunction

    task automatic send_spaces();
        int n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            send_byte(pick_space());
    endtask

    task automatic send_word();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_byte(pick_text());
    endtask

    // property ':' value, with or without the closing ';'
    task automatic send_decls();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            send_spaces();
            send_word();
            send_byte(":");
            send_spaces();
            send_word();
            if (i != n - 1 || $urandom_range(0, 4) != 0)
                send_byte(CHR_SEMI);
        end
    endtask

    // nested rules; closes may fall short or overshoot when broken
    task automatic send_rule(input bit broken);
        int levels;
        int closes;
        levels = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        closes = broken ? $urandom_range(0, levels + 2) : levels;
        for (int i = 0; i < levels; i++)
        begin
            send_spaces();
            send_word();
            if ($urandom_range(0, 1) == 0)
                send_spaces();
            send_byte(CHR_OPEN);
            send_decls();
        end
        for (int i = 0; i < closes; i++)
        begin
            send_spaces();
            send_byte(CHR_CLOSE);
            if (i != closes - 1)
                send_decls();
        end
        send_spaces();
    endtask

    // nest past the limit, then climb back out
    task automatic send_deep_dive();
        int opens;
        int closes;
        opens = $urandom_range(int'(MAX_DEPTH) + 1, int'(MAX_DEPTH) + 4);
        for (int i = 0; i < opens; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_word();
            else if ($urandom_range(0, 1) == 0)
                send_byte(pick_space());
            send_byte(CHR_OPEN);
        end
        closes = $urandom_range(opens - 3, opens + 1);
        for (int i = 0; i < closes; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_word();
            send_byte(CHR_CLOSE);
        end
        send_end();
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(3, 20);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(8'($urandom_range(0, 255)));
                1: send_byte(pick_special());
                default: send_byte(pick_text());
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            send_end();
    endtask

    // one buffer: mostly well formed sheets, some noise and broken nesting
    task automatic send_sheet();
        int pick;
        int rules;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            rules = $urandom_range(1, 3);
            for (int i = 0; i < rules; i++)
                send_rule(1'b0);
            send_end();
        end
        else if (pick < 17)
            send_noise();
        else if (pick < 19)
        begin
            send_rule(1'b1);
            send_end();
        end
        else
            send_deep_dive();
    endtask

    // stimulus
    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (script[i])
        begin
            send_beat(script[i].beat);
            if (script[i].from_model)
                queue_run();
            else
                for (int k = 0; k < int'(script[i].n_typed); k++)
                    pending_beats.push_back(script[i].typed[k]);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_base(p == 2 ? BASE_W'($urandom_range(1, 14)) : PHASE_BASE[p]);
            src_idle  = !(p == 2 || p == PHASES - 1);
            sink_idle = src_idle;
            if (p == 1)
                hold_long = 1'b1;
            if (PHASE_BASE[p] == 4'd15 && p != 2)
                send_deep_dive();
            while (items_sent < TABLE_ROWS + (p + 1) * RANDOM_ITEMS / PHASES)
                send_sheet();
        end
        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side ready: random stall bursts and one long hold-off
    initial
    begin : sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_ready <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 15);
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare each output beat with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %h", $time, res);
                mismatches++;
            end
            else
            begin
                want_beat = pending_beats.pop_front();
                check_field("out_byte", want_beat.out_byte, res.out_byte);
                check_field("is_status", want_beat.is_status, res.is_status);
                check_field("balanced", want_beat.balanced, res.balanced);
                check_field("last_of_run", want_beat.last_of_run, res.last_of_run);
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
